// File: hdl/pow16_mod_exponentiation_unit_assert.svh
// Assertion macros shared by the exponentiation unit files.
`ifndef POW16_MOD_EXPONENTIATION_UNIT_ASSERT_SVH
`define POW16_MOD_EXPONENTIATION_UNIT_ASSERT_SVH

// Condition a at an edge implies condition b at the same edge.
`define P16ME_ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("p16me: same-cycle check failed");

// Condition a at an edge implies condition b at the next edge.
`define P16ME_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("p16me: next-cycle check failed");

// Expression must always hold outside reset.
`define P16ME_ASSERT_ALWAYS(label, clk, rstn, a) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a)) \
        else $error("p16me: invariant check failed");

`endif

// File: hdl/p16me_pkg.sv
`default_nettype none

package p16me_pkg;

    localparam int EXP_BITS_DEF = 48;
    localparam int MOD_BITS_DEF = 32;
    // shift-subtract steps for a multiply by sixteen
    localparam int M16_STEPS    = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQR,
        ST_SQW,
        ST_CHECK,
        ST_M16,
        ST_M16W,
        ST_ADV
    } state_t;

    typedef struct packed {
        logic load;
        logic sq_start;
        logic m16_start;
        logic step;
        logic acc_write;
        logic bit_next;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic cur_bit;
        logic last_bit;
        logic red_last;
        logic acc_trivial;
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/p16me_datapath.sv
`default_nettype none

module p16me_datapath import p16me_pkg::*; #(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    input  wire logic [EXP_BITS-1:0] exponent_in,
    input  wire logic [MOD_BITS-1:0] modulus_in,
    output sts_t                     sts,
    output logic [MOD_BITS-1:0]      acc_out
);

    localparam int IDX_W  = $clog2(EXP_BITS);
    localparam int PROD_W = 2 * MOD_BITS;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    logic [EXP_BITS-1:0] exp_reg;
    logic [MOD_BITS-1:0] mod_reg, mod_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [MOD_BITS:0]   trial;
    logic [MOD_BITS-1:0] rem_step;

    // one restoring reduction step: shift in the next product bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, sh_reg[PROD_W-1]};
        if (trial >= {1'b0, mod_reg}) begin
            rem_step = MOD_BITS'(trial - {1'b0, mod_reg});
        end else begin
            rem_step = trial[MOD_BITS-1:0];
        end
    end

    always_comb begin
        mod_next = mod_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.load) begin
            mod_next = modulus_in;
            // 1 mod m: zero for a modulus of one (and of zero)
            acc_next = (modulus_in[MOD_BITS-1:1] != '0) ? MOD_BITS'(1) : '0;
            rem_next = '0;
            idx_next = IDX_W'(EXP_BITS - 1);
        end
        if (cmd.sq_start) begin
            rem_next = '0;
            sh_next  = PROD_W'(acc_reg) * PROD_W'(acc_reg);
            cnt_next = CNT_W'(PROD_W);
        end
        if (cmd.m16_start) begin
            rem_next = acc_reg;
            sh_next  = '0;
            cnt_next = CNT_W'(M16_STEPS);
        end
        if (cmd.step) begin
            rem_next = rem_step;
            sh_next  = {sh_reg[PROD_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.acc_write) begin
            acc_next = rem_reg;
        end
        if (cmd.bit_next) begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= '0;
            acc_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            mod_reg <= mod_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            exp_reg <= exponent_in;
        end
        sh_reg <= sh_next;
    end

    always_comb begin
        sts.cur_bit     = exp_reg[idx_reg];
        sts.last_bit    = (idx_reg == '0);
        sts.red_last    = (cnt_reg == CNT_W'(1));
        sts.acc_trivial = (acc_reg[MOD_BITS-1:1] == '0);
    end

    assign acc_out = acc_reg;

`include "pow16_mod_exponentiation_unit_assert.svh"
    `P16ME_ASSERT_SAME(a_step_has_count, aclk, aresetn, cmd.step, cnt_reg != '0)
    `P16ME_ASSERT_ALWAYS(a_acc_below_mod, aclk, aresetn, mod_reg == '0 || acc_reg < mod_reg)
    `P16ME_ASSERT_ALWAYS(a_rem_below_mod, aclk, aresetn, mod_reg == '0 || rem_reg < mod_reg)

endmodule

`default_nettype wire

// File: hdl/p16me_ctrl.sv
`default_nettype none

module p16me_ctrl import p16me_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic out_free,
    input  wire sts_t sts,
    output logic      idle,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   done_pending_reg, done_pending_next;

    // next state
    always_comb begin
        state_next        = state_reg;
        done_pending_next = done_pending_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // squaring zero or one changes nothing
                state_next = sts.acc_trivial ? ST_CHECK : ST_SQR;
            end
            ST_SQR: begin
                if (sts.red_last) begin
                    state_next = ST_SQW;
                end
            end
            ST_SQW:   state_next = ST_CHECK;
            ST_CHECK: state_next = sts.cur_bit ? ST_M16 : ST_ADV;
            ST_M16: begin
                if (sts.red_last) begin
                    state_next = ST_M16W;
                end
            end
            ST_M16W:  state_next = ST_ADV;
            ST_ADV: begin
                if (!sts.last_bit) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
        done_pending_next = (state_next == ST_ADV) && sts.last_bit;
    end

    // outputs
    always_comb begin
        cmd  = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                idle     = 1'b1;
                cmd.load = start;
            end
            ST_SCAN:  cmd.sq_start  = !sts.acc_trivial;
            ST_SQR:   cmd.step      = 1'b1;
            ST_SQW:   cmd.acc_write = 1'b1;
            ST_CHECK: cmd.m16_start = sts.cur_bit;
            ST_M16:   cmd.step      = 1'b1;
            ST_M16W:  cmd.acc_write = 1'b1;
            ST_ADV: begin
                cmd.bit_next = !sts.last_bit;
                cmd.store    = sts.last_bit && out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            done_pending_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            done_pending_reg <= done_pending_next;
        end
    end

`include "pow16_mod_exponentiation_unit_assert.svh"
    `P16ME_ASSERT_ALWAYS(a_one_command, aclk, aresetn, $onehot0(cmd))
    `P16ME_ASSERT_SAME(a_store_on_last, aclk, aresetn, cmd.store, done_pending_reg || sts.last_bit)

endmodule

`default_nettype wire

// File: hdl/pow16_mod_exponentiation_unit.sv
`default_nettype none

// Channel  Ports                          Direction  Meaning
// s_       s_valid s_ready s_exponent     in         one transaction: exponent and modulus
//          s_modulus
// m_       m_valid m_ready m_residue      out        one transaction: 16^exponent mod modulus
//
// Sequence: accept, then per exponent bit scan, check and advance, with the modular
//   square (skipped while the accumulator is 0 or 1) between scan and check, and the
//   multiply by sixteen between check and advance when the bit is set.
// Both reductions run on the shift-subtract reduction loop in the datapath, one
//   quotient bit per cycle, shared by the square and the multiply by sixteen.
// Reset: aresetn, synchronous and active low; clears controller and output valid.
// Stalls: a finished result sits in the output register; the next transaction
//   is accepted and computed while it waits, and only the final write waits on it.

module pow16_mod_exponentiation_unit import p16me_pkg::*; #(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [EXP_BITS-1:0] s_exponent,
    input  wire logic [MOD_BITS-1:0] s_modulus,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [MOD_BITS-1:0]      m_residue
);

    cmd_t                cmd;
    sts_t                sts;
    logic                idle;
    logic                out_free;
    logic [MOD_BITS-1:0] acc;
    logic                m_valid_reg, m_valid_next;
    logic [MOD_BITS-1:0] m_residue_reg;

    // the result register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = idle;

    p16me_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .out_free (out_free),
        .sts      (sts),
        .idle     (idle),
        .cmd      (cmd)
    );

    p16me_datapath #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .exponent_in (s_exponent),
        .modulus_in  (s_modulus),
        .sts         (sts),
        .acc_out     (acc)
    );

    // hold the result until taken; load on store, drop on drain
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.store) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            m_residue_reg <= acc;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_residue = m_residue_reg;

`include "pow16_mod_exponentiation_unit_assert.svh"
    `P16ME_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.store && m_valid_reg, m_ready)

endmodule

`default_nettype wire
